// ----- design/lct_pkg.sv -----
// Shared types, constants and helpers for the linked chain table.
// Used by every module of the block; depends on nothing else.
package lct_pkg;

  localparam int unsigned Nodes   = 64;
  localparam int unsigned NodeIdW = 6;
  localparam int unsigned MaxRun  = 64;
  localparam int unsigned Limit   = (Nodes < MaxRun) ? Nodes : MaxRun;
  localparam int unsigned CntW    = $clog2(Limit + 1);

  typedef logic [NodeIdW-1:0] node_id_t;
  typedef logic [CntW-1:0]    cnt_t;

  typedef enum logic [1:0] {
    ActLink   = 2'd0,
    ActUnlink = 2'd1,
    ActList   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StBack,
    StFwd,
    StOne
  } state_e;

  typedef struct packed {
    action_e  action;
    node_id_t first_node;
    node_id_t second_node;
  } lct_in_t;

  typedef struct packed {
    node_id_t node_id;
    logic     last_of_chain;
  } lct_out_t;

  // Write side of both link tables.
  typedef struct packed {
    logic     pred_we;
    node_id_t pred_addr;
    node_id_t pred_data;
    logic     succ_we;
    node_id_t succ_addr;
    node_id_t succ_data;
  } lct_wr_t;

  // Read side of both link tables.
  typedef struct packed {
    logic     pred_re;
    node_id_t pred_addr;
    logic     succ_re;
    node_id_t succ_addr;
  } lct_rd_t;

  // Verdict of the step unit for the current walk position.
  typedef struct packed {
    logic link_end;
    logic limit_hit;
  } lct_step_t;

  function automatic logic in_range(node_id_t id);
    return ({1'b0, id} < (NodeIdW + 1)'(Nodes));
  endfunction

endpackage

// ----- design/linked_chain_table_unit.sv -----
// A link or unlink beat writes both link memories when it is accepted. A list beat is
// accepted, then reads predecessor links back to the head (up to 64 reads), then emits
// one result per successor link (up to 64), holding while the output register is full.
// Throughput: one item at a time; the single read port of each link memory sets the pace.
// Reset: asynchronous, active low; every link reads as its own node at once through valid
// bits, so there is no clearing pass and the block is ready as soon as reset is released.
module linked_chain_table_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lct_pkg::lct_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lct_pkg::lct_out_t out_item_o
);
  import lct_pkg::*;

  // Sequencer state. The walk position now_q and the step counter cnt_q are shared
  // between the backward walk and the forward emission.
  state_e   state_q, state_d;
  node_id_t now_q, now_d;
  cnt_t     cnt_q, cnt_d;

  lct_wr_t   wr;
  lct_rd_t   rd;
  lct_step_t step;
  node_id_t  pred_rdata, succ_rdata, link_val;

  // Output register: it holds one finished beat so the sequencer can prepare the next.
  logic     out_valid_q;
  lct_out_t out_item_q, out_item_d;
  logic     out_load, out_free;

  lct_link_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .rd_i         (rd),
    .pred_rdata_o (pred_rdata),
    .succ_rdata_o (succ_rdata)
  );

  // The backward walk looks at predecessor links, the forward run at successor links.
  assign link_val = (state_q == StBack) ? pred_rdata : succ_rdata;

  lct_step_unit u_step (
    .now_i  (now_q),
    .link_i (link_val),
    .cnt_i  (cnt_q),
    .step_o (step)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      now_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    cnt_d      = cnt_q;
    wr         = '0;
    rd         = '0;
    out_load   = 1'b0;
    out_item_d = '0;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          case (in_item_i.action)
            ActLink: begin
              // Second node follows first node; nodes out of range change nothing.
              if (in_range(in_item_i.first_node) && in_range(in_item_i.second_node)) begin
                wr.succ_we   = 1'b1;
                wr.succ_addr = in_item_i.first_node;
                wr.succ_data = in_item_i.second_node;
                wr.pred_we   = 1'b1;
                wr.pred_addr = in_item_i.second_node;
                wr.pred_data = in_item_i.first_node;
              end
            end
            ActUnlink: begin
              // Cutting a link points both ends back at themselves.
              if (in_range(in_item_i.first_node) && in_range(in_item_i.second_node)) begin
                wr.succ_we   = 1'b1;
                wr.succ_addr = in_item_i.first_node;
                wr.succ_data = in_item_i.first_node;
                wr.pred_we   = 1'b1;
                wr.pred_addr = in_item_i.second_node;
                wr.pred_data = in_item_i.second_node;
              end
            end
            ActList: begin
              now_d = in_item_i.first_node;
              cnt_d = '0;
              if (in_range(in_item_i.first_node)) begin
                rd.pred_re   = 1'b1;
                rd.pred_addr = in_item_i.first_node;
                state_d      = StBack;
              end else begin
                // A node outside the table lists as itself alone.
                state_d = StOne;
              end
            end
            default: begin
              // The unused action code is dropped without any result.
            end
          endcase
        end
      end

      StBack: begin
        // The predecessor of now_q is on the read port. Either the head is found, or we
        // step to the predecessor and read its link in the same cycle.
        if (step.link_end) begin
          rd.succ_re   = 1'b1;
          rd.succ_addr = now_q;
          cnt_d        = '0;
          state_d      = StFwd;
        end else begin
          now_d = pred_rdata;
          if (step.limit_hit) begin
            // Step bound reached on a cyclic chain: the node reached counts as head.
            rd.succ_re   = 1'b1;
            rd.succ_addr = pred_rdata;
            cnt_d        = '0;
            state_d      = StFwd;
          end else begin
            rd.pred_re   = 1'b1;
            rd.pred_addr = pred_rdata;
            cnt_d        = cnt_q + cnt_t'(1);
          end
        end
      end

      StFwd: begin
        // Emit now_q once the output register has room; the successor read data holds
        // meanwhile because no new read is issued.
        if (out_free) begin
          out_load                 = 1'b1;
          out_item_d.node_id       = now_q;
          out_item_d.last_of_chain = step.link_end || step.limit_hit;
          if (step.link_end || step.limit_hit) begin
            state_d = StIdle;
          end else begin
            now_d        = succ_rdata;
            cnt_d        = cnt_q + cnt_t'(1);
            rd.succ_re   = 1'b1;
            rd.succ_addr = succ_rdata;
          end
        end
      end

      StOne: begin
        if (out_free) begin
          out_load                 = 1'b1;
          out_item_d.node_id       = now_q;
          out_item_d.last_of_chain = 1'b1;
          state_d                  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // The step counter never passes the walk bound.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} <= (CntW + 1)'(Limit)))
    else $error("step counter beyond walk bound");

  // A beat marked as tail always ends the list run.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_item_d.last_of_chain) |=> (state_q == StIdle))
    else $error("tail beat did not end the run");

  // No result beat is produced during the backward walk.
  a_back_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StBack) |-> !out_load)
    else $error("beat emitted during backward walk");

  // Link tables are only written while an item is taken in the idle state.
  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.pred_we || wr.succ_we) |-> (in_ready_o && in_valid_i))
    else $error("link write outside of an accepted beat");
`endif

endmodule

// ----- design/lct_link_store.sv -----
// Predecessor and successor link memories with registered read ports.
// Depends on lct_pkg; per-entry valid bits make unwritten entries read as their own index.
module lct_link_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lct_pkg::lct_wr_t wr_i,
  input  lct_pkg::lct_rd_t rd_i,
  output lct_pkg::node_id_t pred_rdata_o,
  output lct_pkg::node_id_t succ_rdata_o
);
  import lct_pkg::*;

  node_id_t        pred_mem [Nodes];
  node_id_t        succ_mem [Nodes];
  logic [Nodes-1:0] pred_vld_q;
  logic [Nodes-1:0] succ_vld_q;

  node_id_t pred_raw_q, pred_addr_q;
  node_id_t succ_raw_q, succ_addr_q;
  logic     pred_hit_q, succ_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_vld_q <= '0;
      succ_vld_q <= '0;
    end else begin
      if (wr_i.pred_we) begin
        pred_vld_q[wr_i.pred_addr] <= 1'b1;
      end
      if (wr_i.succ_we) begin
        succ_vld_q[wr_i.succ_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.pred_we) begin
      pred_mem[wr_i.pred_addr] <= wr_i.pred_data;
    end
    if (wr_i.succ_we) begin
      succ_mem[wr_i.succ_addr] <= wr_i.succ_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.pred_re) begin
      pred_raw_q  <= pred_mem[rd_i.pred_addr];
      pred_hit_q  <= pred_vld_q[rd_i.pred_addr];
      pred_addr_q <= rd_i.pred_addr;
    end
    if (rd_i.succ_re) begin
      succ_raw_q  <= succ_mem[rd_i.succ_addr];
      succ_hit_q  <= succ_vld_q[rd_i.succ_addr];
      succ_addr_q <= rd_i.succ_addr;
    end
  end

  // An entry never written reads as its own index, taken from the registered read address.
  assign pred_rdata_o = pred_hit_q ? pred_raw_q : pred_addr_q;
  assign succ_rdata_o = succ_hit_q ? succ_raw_q : succ_addr_q;

endmodule

// ----- design/lct_step_unit.sv -----
// Shared compare unit used by both the backward and the forward walk.
// Depends on lct_pkg; decides whether the chain ends or the step bound is reached.
module lct_step_unit (
  input  lct_pkg::node_id_t  now_i,
  input  lct_pkg::node_id_t  link_i,
  input  lct_pkg::cnt_t      cnt_i,
  output lct_pkg::lct_step_t step_o
);
  import lct_pkg::*;

  logic [CntW:0] cnt_next;

  assign cnt_next         = {1'b0, cnt_i} + (CntW + 1)'(1);
  assign step_o.link_end  = (link_i == now_i) || !in_range(link_i);
  assign step_o.limit_hit = (cnt_next >= (CntW + 1)'(Limit));

endmodule
